// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define DPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DPS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/dps_pkg.sv =====
`timescale 1ns / 1ps

package dps_pkg;

	// Operation codes of an input item
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result status codes
	typedef enum logic [2:0] {
		STS_LOADED   = 3'd0,
		STS_FULL     = 3'd1,
		STS_ZERO     = 3'd2,
		STS_REQUEUED = 3'd3,
		STS_FINISHED = 3'd4,
		STS_EMPTY    = 3'd5
	} status_t;

	// The command that every cell of the queue carries out
	typedef enum logic [1:0] {
		MODE_HOLD    = 2'd0,
		MODE_INSERT  = 2'd1,
		MODE_POP     = 2'd2,
		MODE_POP_INS = 2'd3
	} cell_mode_t;

	// Task fields that ride along with the priority
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] need;
		logic [15:0] done;
	} task_info_t;

	// Command broadcast to all cells
	typedef struct packed {
		cell_mode_t mode;
		task_info_t info;
	} cell_ctl_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] task_id;
		logic [15:0] start_priority;
		logic [15:0] needed_time;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] ran_id;
		logic [15:0] time_left;
		logic [31:0] turnaround;
		logic [4:0]  queue_count;
	} out_item_t;

endpackage

// ===== rtl/dps_stream_if.sv =====
`timescale 1ns / 1ps

interface dps_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/dynamic_priority_scheduler_top.sv =====
`timescale 1ns / 1ps
// Each result is registered into the output register, or into the skid entry while res stalls.
// Throughput: one item per cycle while the skid entry is empty; every cell of the queue
// compares against the broadcast key and shifts in the same cycle, for loads and pop-and-requeue alike.
// A two-entry output buffer keeps cmd ready while one result waits on res.
// Reset (arst_n low): queue empty, tick count zero, no result pending.

module dynamic_priority_scheduler_top import dps_pkg::*; #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	dps_stream_if.sink   cmd,
	dps_stream_if.source res
);

	`include "assert_macros.svh"

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic                     acc;
	in_item_t                 item;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_n;
	logic [31:0]              tick_q;
	logic [31:0]              tick_inc;
	cell_ctl_t                ctl;
	logic [PRIORITY_BITS-1:0] key_prio;
	logic [PRIORITY_BITS-1:0] head_prio_inc;
	logic [15:0]              done_inc;
	out_item_t                result;
	out_item_t                out_q;
	out_item_t                skid_q;
	logic                     out_v_q;
	logic                     skid_v_q;
	logic                     res_pop;

	logic [QUEUE_DEPTH-1:0]   valid_vec;
	logic [QUEUE_DEPTH-1:0]   le_vec;
	task_info_t               info_arr [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0] prio_arr [QUEUE_DEPTH];

	assign item      = cmd.payload;
	assign cmd.ready = !skid_v_q;
	assign acc       = cmd.valid && cmd.ready;
	assign tick_inc  = tick_q + 32'd1;
	assign done_inc  = info_arr[0].done + 16'd1;

	// Saturate the head priority number on requeue
	assign head_prio_inc = (prio_arr[0] == {PRIORITY_BITS{1'b1}}) ?
		prio_arr[0] : prio_arr[0] + 1'b1;

	// Decode the item into a queue command and a result
	always_comb begin
		ctl.mode   = MODE_HOLD;
		ctl.info   = '{id: item.task_id, need: item.needed_time, done: 16'd0};
		key_prio   = PRIORITY_BITS'(item.start_priority);
		count_n    = count_q;
		result     = '0;
		if (item.operation == OP_LOAD) begin
			if (count_q == CW'(QUEUE_DEPTH)) begin
				result.status = STS_FULL;
			end else if (item.needed_time == 16'd0) begin
				result.status = STS_ZERO;
			end else begin
				result.status = STS_LOADED;
				ctl.mode      = MODE_INSERT;
				count_n       = count_q + 1'b1;
			end
		end else if (!valid_vec[0]) begin
			result.status = STS_EMPTY;
		end else begin
			result.ran_id = info_arr[0].id;
			if (done_inc >= info_arr[0].need) begin
				result.status     = STS_FINISHED;
				result.turnaround = tick_inc;
				ctl.mode          = MODE_POP;
				count_n           = count_q - 1'b1;
			end else begin
				result.status    = STS_REQUEUED;
				result.time_left = info_arr[0].need - done_inc;
				ctl.mode         = MODE_POP_INS;
				ctl.info.id      = info_arr[0].id;
				ctl.info.need    = info_arr[0].need;
				ctl.info.done    = done_inc;
				key_prio         = head_prio_inc;
			end
		end
		result.queue_count = 5'(count_n);
		if (!acc) begin
			ctl.mode = MODE_HOLD;
		end
	end

	// Build the chain of queue cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                     l_valid;
		logic                     l_le;
		task_info_t               l_info;
		logic [PRIORITY_BITS-1:0] l_prio;
		logic                     r_valid;
		logic                     r_le;
		task_info_t               r_info;
		logic [PRIORITY_BITS-1:0] r_prio;

		if (i == 0) begin : g_first
			assign l_valid = 1'b1;
			assign l_le    = 1'b1;
			assign l_info  = '0;
			assign l_prio  = '0;
		end else begin : g_mid_l
			assign l_valid = valid_vec[i-1];
			assign l_le    = le_vec[i-1];
			assign l_info  = info_arr[i-1];
			assign l_prio  = prio_arr[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_valid = 1'b0;
			assign r_le    = 1'b0;
			assign r_info  = '0;
			assign r_prio  = '0;
		end else begin : g_mid_r
			assign r_valid = valid_vec[i+1];
			assign r_le    = le_vec[i+1];
			assign r_info  = info_arr[i+1];
			assign r_prio  = prio_arr[i+1];
		end

		dps_cell #(
			.PRIORITY_BITS (PRIORITY_BITS),
			.HEAD          (i == 0)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.key_prio    (key_prio),
			.left_valid  (l_valid),
			.left_le     (l_le),
			.left_info   (l_info),
			.left_prio   (l_prio),
			.right_valid (r_valid),
			.right_le    (r_le),
			.right_info  (r_info),
			.right_prio  (r_prio),
			.valid       (valid_vec[i]),
			.le          (le_vec[i]),
			.info        (info_arr[i]),
			.prio        (prio_arr[i])
		);
	end

	// Advance the task count and the tick count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tick_q  <= '0;
		end else if (acc) begin
			count_q <= count_n;
			if (ctl.mode == MODE_POP || ctl.mode == MODE_POP_INS) begin
				tick_q <= tick_inc;
			end
		end
	end

	// Hold results in an output register backed by a skid entry
	assign res_pop     = out_v_q && res.ready;
	assign res.valid   = out_v_q;
	assign res.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (res_pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (acc) begin
			if (out_v_q && !res_pop) begin
				skid_v_q <= 1'b1;
			end
			out_v_q <= 1'b1;
		end else if (res_pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (res_pop) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (out_v_q && !res_pop) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	`DPS_ASSERT(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "task count beyond queue depth")
	`DPS_ASSERT(a_count_cells, $countones(valid_vec) == count_q, "cell occupancy disagrees with count")
	`DPS_ASSERT(a_empty_tick, acc && item.operation == OP_TICK && !valid_vec[0] |=> $stable(tick_q), "tick count moved on an empty queue")
	`DPS_ASSERT(a_skid_order, !skid_v_q || out_v_q, "skid entry held without an output entry")

endmodule

// ===== rtl/dps_cell.sv =====
`timescale 1ns / 1ps

module dps_cell import dps_pkg::*; #(
	parameter int PRIORITY_BITS = 16,
	parameter bit HEAD = 1'b0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic [PRIORITY_BITS-1:0] key_prio,
	input  logic                     left_valid,
	input  logic                     left_le,
	input  task_info_t               left_info,
	input  logic [PRIORITY_BITS-1:0] left_prio,
	input  logic                     right_valid,
	input  logic                     right_le,
	input  task_info_t               right_info,
	input  logic [PRIORITY_BITS-1:0] right_prio,
	output logic                     valid,
	output logic                     le,
	output task_info_t               info,
	output logic [PRIORITY_BITS-1:0] prio
);

	logic                     valid_q;
	task_info_t               info_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic                     take_key;
	logic                     take_left;
	logic                     take_right;

	// Stay ahead of the key when queued and not less urgent
	assign le    = valid_q && (prio_q <= key_prio);
	assign valid = valid_q;
	assign info  = info_q;
	assign prio  = prio_q;

	// Pick the data source for this cell
	always_comb begin
		take_key   = 1'b0;
		take_left  = 1'b0;
		take_right = 1'b0;
		case (ctl.mode)
			MODE_INSERT: begin
				take_key  = !le && left_le;
				take_left = !le && !left_le;
			end
			MODE_POP: begin
				take_right = 1'b1;
			end
			MODE_POP_INS: begin
				take_right = right_le;
				take_key   = !right_le && (HEAD || le);
			end
			default: begin
			end
		endcase
	end

	// Track occupancy; the queue stays packed from the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.mode)
				MODE_INSERT: valid_q <= valid_q || left_valid;
				MODE_POP:    valid_q <= right_valid;
				default:     valid_q <= valid_q;
			endcase
		end
	end

	// Load, shift or hold the task data
	always_ff @(posedge clk) begin
		if (take_key) begin
			info_q <= ctl.info;
			prio_q <= key_prio;
		end else if (take_left) begin
			info_q <= left_info;
			prio_q <= left_prio;
		end else if (take_right) begin
			info_q <= right_info;
			prio_q <= right_prio;
		end
	end

endmodule
